// ===== rtl/akf_pkg.sv =====
// ----------------------------------------------------------------------------
// akf_pkg
// Shared types and constants of the angle Kalman filter step unit.
// ----------------------------------------------------------------------------
package akf_pkg;

    localparam int unsigned CFG_BITS = 31;
    localparam int unsigned DT_BITS  = 16;
    localparam int unsigned DT_FRAC  = 16;
    localparam int unsigned IO_BITS  = 32;

    typedef enum logic [1:0] {
        REG_Q_ANGLE   = 2'd0,
        REG_Q_BIAS    = 2'd1,
        REG_R_MEASURE = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_DIV = 2'd1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_ISSUE = 3'd1,
        ST_WAIT  = 3'd2,
        ST_SUM   = 3'd3,
        ST_OUT   = 3'd4
    } t_state;

    typedef struct packed {
        logic start;
        t_op  op;
        logic short_shift;
    } t_alu_req;

endpackage

// ===== rtl/akf_alu.sv =====
// ----------------------------------------------------------------------------
// akf_alu
// Shared multicycle unit: rounded saturating multiply (radix-2 shift-add)
// and rounded saturating divide (restoring, one quotient bit per cycle).
// ----------------------------------------------------------------------------
module akf_alu #(
    parameter int unsigned WORD_BITS = 32,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  akf_pkg::t_alu_req           i_req,
    input  logic signed [WORD_BITS-1:0] i_a,
    input  logic signed [WORD_BITS-1:0] i_b,
    output logic                        o_done,
    output logic signed [WORD_BITS-1:0] o_res
);
    import akf_pkg::*;

    localparam int unsigned W   = WORD_BITS;
    localparam int unsigned PW  = 2 * W + 2;
    localparam int unsigned NW  = W + FRAC_BITS + 1;
    localparam int unsigned CW  = $clog2(PW + 1);

    logic [W-1:0]  r_ma;
    logic [W-1:0]  r_mb;
    logic [PW-1:0] r_acc;
    logic [W:0]    r_rem;
    logic [NW-1:0] r_num;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_neg;
    t_op           r_op;
    logic          r_short;
    logic          r_done;
    logic signed [W-1:0] r_res;

    logic [W-1:0]  ma;
    logic [W-1:0]  mb;
    logic [W:0]    rem_sh;
    logic [W:0]    rem_sub;
    logic [PW-1:0] rnd;
    logic [PW-1:0] shv;
    logic [PW-1:0] lim;
    logic [PW-1:0] magv;
    logic signed [W-1:0] fin;
    logic [CW-1:0] n_cnt;

    assign ma = i_a[W-1] ? W'(-i_a) : W'(i_a);
    assign mb = i_b[W-1] ? W'(-i_b) : W'(i_b);
    assign rem_sh  = {r_rem[W-1:0], r_num[NW-1]};
    assign rem_sub = rem_sh - {1'b0, r_mb};
    assign n_cnt   = r_cnt - CW'(1);

    always_comb begin
        lim = PW'(1) << (W - 1);
        if (r_op == OP_MUL) begin
            rnd = r_short ? (PW'(1) << (DT_FRAC - 1)) : (PW'(1) << (FRAC_BITS - 1));
            shv = r_short ? ((r_acc + rnd) >> DT_FRAC) : ((r_acc + rnd) >> FRAC_BITS);
        end else begin
            rnd = '0;
            shv = r_acc;
        end
        magv = (shv > lim) ? lim : shv;
        if (r_neg) begin
            fin = W'(-magv);
        end else begin
            fin = (magv == lim) ? {1'b0, {(W-1){1'b1}}} : W'(magv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_op    <= i_req.op;
                r_short <= i_req.short_shift;
                r_neg   <= i_a[W-1] ^ i_b[W-1];
                r_ma    <= ma;
                r_mb    <= mb;
                r_acc   <= '0;
                r_rem   <= '0;
                if (i_req.op == OP_MUL) begin
                    r_cnt <= CW'(W);
                end else begin
                    r_num <= ({1'b0, ma, {FRAC_BITS{1'b0}}}) + NW'(mb >> 1);
                    r_cnt <= CW'(NW);
                end
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= fin;
                end else if (r_op == OP_MUL) begin
                    if (r_mb[0]) begin
                        r_acc <= r_acc + (PW'(r_ma) << (W - r_cnt));
                    end
                    r_mb  <= r_mb >> 1;
                    r_cnt <= n_cnt;
                end else begin
                    r_num <= r_num << 1;
                    if (!rem_sub[W]) begin
                        r_rem <= rem_sub;
                        r_acc <= {r_acc[PW-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_acc <= {r_acc[PW-2:0], 1'b0};
                    end
                    r_cnt <= n_cnt;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    ap_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("alu done while busy");
    ap_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy) else $error("alu did not start");
    ap_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("alu done held");

endmodule

// ===== rtl/angle_kalman_filter_step_unit.sv =====
// ----------------------------------------------------------------------------
// angle_kalman_filter_step_unit
// Two-state angle and gyro bias Kalman filter step, signed fixed point.
// ----------------------------------------------------------------------------
// Each beat runs up to 13 operations on one shared multiply/divide unit:
// eleven multiplies and two divides. Five prediction multiplies come
// first, then the innovation sum, the two divides and six update
// multiplies, then the output load and a return to idle. A zero
// innovation variance skips the divides and the update. The unit is not
// ready while a beat is in work. The result is held in an output register
// until taken; the next beat may start meanwhile, and a finished beat
// waits in the unit while the output register is still full.
module angle_kalman_filter_step_unit #(
    parameter int unsigned WORD_BITS = 32,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic signed [31:0] i_gyro_rate,
    input  logic signed [31:0] i_measured_angle,
    input  logic [15:0] i_time_step,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_angle_estimate,
    output logic signed [31:0] o_bias_estimate
);
    import akf_pkg::*;

    localparam int unsigned W = WORD_BITS;
    localparam logic signed [W+3:0] WMAX = (W+4)'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [W+3:0] WMIN = -WMAX - (W+4)'(1);

    // step list: op a b destination
    typedef enum logic [4:0] {
        K_ANG, K_QA, K_PC, K_P3A, K_QB, K_S0, K_K0, K_K1,
        K_UA, K_UB, K_U0, K_U1, K_U2, K_U3, K_FIN
    } t_step;

    logic [CFG_BITS-1:0] r_qa, r_qb, r_rm;
    logic signed [W-1:0] r_ang, r_bias, r_p0, r_p1, r_p2, r_p3;
    logic signed [W-1:0] r_gy, r_ms, r_dt, r_pa, r_pp0, r_pp1, r_pp2, r_pp3;
    logic signed [W-1:0] r_y, r_k0, r_k1;
    logic signed [W-1:0] innov;
    logic signed [W-1:0] r_t0, r_t1, r_t2;
    t_step  r_step, n_step;
    t_state r_st, n_st;
    logic   r_ov;
    logic signed [31:0] r_oa, r_ob;

    t_alu_req req;
    logic signed [W-1:0] opa, opb, ares;
    logic adone;
    logic acc_in, acc_out;
    logic out_load;

    function automatic logic signed [W-1:0] sat(input logic signed [W+3:0] v);
        if (v > WMAX) return WMAX[W-1:0];
        if (v < WMIN) return WMIN[W-1:0];
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] satl(input longint v);
        if (v > longint'(WMAX)) return WMAX[W-1:0];
        if (v < longint'(WMIN)) return WMIN[W-1:0];
        return W'(v);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [W-1:0] v);
        longint e;
        e = longint'(v);
        if (e > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (e < -64'sh80000000) return 32'sh80000000;
        return 32'(e);
    endfunction

    function automatic logic signed [W+3:0] ex(input logic signed [W-1:0] v);
        return (W+4)'(v);
    endfunction

    function automatic logic signed [W-1:0] cfgw(input logic [CFG_BITS-1:0] v);
        return satl(longint'(v));
    endfunction

    function automatic logic signed [W-1:0] inw(input logic signed [31:0] v);
        return satl(longint'(v));
    endfunction

    assign pready  = 1'b1;
    assign acc_in  = i_valid && !o_stall;
    assign acc_out = o_valid && !i_stall;
    assign o_stall = (r_st != ST_IDLE);
    assign o_valid = r_ov;
    assign o_angle_estimate = r_oa;
    assign o_bias_estimate  = r_ob;
    assign out_load = (r_st == ST_OUT) && (!r_ov || acc_out);

    always_comb begin
        case (paddr[3:2])
            REG_Q_ANGLE:   prdata = {1'b0, r_qa};
            REG_Q_BIAS:    prdata = {1'b0, r_qb};
            REG_R_MEASURE: prdata = {1'b0, r_rm};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= CFG_BITS'(66);
            r_qb <= CFG_BITS'(197);
            r_rm <= CFG_BITS'(1966);
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_Q_ANGLE:   r_qa <= pwdata[CFG_BITS-1:0];
                REG_Q_BIAS:    r_qb <= pwdata[CFG_BITS-1:0];
                REG_R_MEASURE: r_rm <= pwdata[CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // operand select per step
    always_comb begin
        req.start = (r_st == ST_ISSUE);
        req.op = OP_MUL;
        req.short_shift = 1'b1;
        opa = r_dt;
        opb = '0;
        case (r_step)
            K_ANG: opb = sat(ex(r_gy) - ex(r_bias));
            K_QA:  opb = cfgw(r_qa);
            K_PC:  opb = sat(ex(r_p1) + ex(r_p2));
            K_P3A: opb = r_p3;
            K_QB:  opb = cfgw(r_qb);
            K_K0: begin
                req.op = OP_DIV; opa = r_pp0; opb = innov;
            end
            K_K1: begin
                req.op = OP_DIV; opa = r_pp2; opb = innov;
            end
            K_UA: begin
                req.short_shift = 1'b0; opa = r_k0; opb = r_y;
            end
            K_UB: begin
                req.short_shift = 1'b0; opa = r_k1; opb = r_y;
            end
            K_U0: begin
                req.short_shift = 1'b0; opa = r_k0; opb = r_pp0;
            end
            K_U1: begin
                req.short_shift = 1'b0; opa = r_k0; opb = r_pp1;
            end
            K_U2: begin
                req.short_shift = 1'b0; opa = r_k1; opb = r_pp0;
            end
            K_U3: begin
                req.short_shift = 1'b0; opa = r_k1; opb = r_pp1;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_st = r_st;
        n_step = r_step;
        case (r_st)
            ST_IDLE:  if (acc_in) n_st = ST_ISSUE;
            ST_ISSUE: n_st = ST_WAIT;
            ST_WAIT: begin
                if (adone) begin
                    if (r_step == K_QB) begin
                        n_st = ST_SUM; n_step = K_S0;
                    end else if (r_step == K_U3) begin
                        n_st = ST_OUT; n_step = K_FIN;
                    end else begin
                        n_st = ST_ISSUE; n_step = t_step'(r_step + 5'd1);
                    end
                end
            end
            ST_SUM: begin
                if (innov == '0) begin
                    n_st = ST_OUT; n_step = K_FIN;
                end else begin
                    n_st = ST_ISSUE; n_step = K_K0;
                end
            end
            ST_OUT:  if (!r_ov || acc_out) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
        if (r_st == ST_IDLE) n_step = K_ANG;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_step <= K_ANG;
            r_ov   <= 1'b0;
            r_ang  <= '0; r_bias <= '0;
            r_p0 <= '0; r_p1 <= '0; r_p2 <= '0; r_p3 <= '0;
        end else begin
            r_st   <= n_st;
            r_step <= n_step;
            if (out_load) begin
                r_ov <= 1'b1;
                r_oa <= sat32(r_ang);
                r_ob <= sat32(r_bias);
            end else if (acc_out) begin
                r_ov <= 1'b0;
            end
            if (acc_in) begin
                r_gy <= inw(i_gyro_rate);
                r_ms <= inw(i_measured_angle);
                r_dt <= W'(i_time_step);
            end
            if (r_st == ST_WAIT && adone) begin
                case (r_step)
                    K_ANG: r_pa <= sat(ex(r_ang) + ex(ares));
                    K_QA:  r_t0 <= ares;
                    K_PC:  r_t1 <= ares;
                    K_P3A: r_t2 <= ares;
                    K_QB: begin
                        r_pp0 <= sat(ex(r_p0) + ex(r_t0) - ex(r_t1));
                        r_pp1 <= sat(ex(r_p1) - ex(r_t2));
                        r_pp2 <= sat(ex(r_p2) - ex(r_t2));
                        r_pp3 <= sat(ex(r_p3) + ex(ares));
                    end
                    K_K0: r_k0 <= ares;
                    K_K1: r_k1 <= ares;
                    K_UA: r_ang <= sat(ex(r_pa) + ex(ares));
                    K_UB: r_bias <= sat(ex(r_bias) + ex(ares));
                    K_U0: r_p0 <= sat(ex(r_pp0) - ex(ares));
                    K_U1: r_p1 <= sat(ex(r_pp1) - ex(ares));
                    K_U2: r_p2 <= sat(ex(r_pp2) - ex(ares));
                    K_U3: r_p3 <= sat(ex(r_pp3) - ex(ares));
                    default: ;
                endcase
            end
            if (r_st == ST_SUM) begin
                r_y <= sat(ex(r_ms) - ex(r_pa));
                if (innov == '0) begin
                    r_ang <= r_pa;
                    r_p0 <= r_pp0; r_p1 <= r_pp1; r_p2 <= r_pp2; r_p3 <= r_pp3;
                end
            end
        end
    end

    // innovation variance; ready once the predicted P00 is in
    assign innov = sat(ex(r_pp0) + ex(cfgw(r_rm)));

    akf_alu #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .i_a    (opa),
        .i_b    (opb),
        .o_done (adone),
        .o_res  (ares)
    );

    ap_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> o_stall) else $error("beat taken while busy");
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_angle_estimate)))
        else $error("result dropped");
    ap_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_OUT) |=> o_valid) else $error("result lost");

endmodule

// ===== tb/angle_kalman_filter_step_unit_test.sv =====
// ----------------------------------------------------------------------------
// angle_kalman_filter_step_unit_test
// Self-checking bench for the angle Kalman filter step unit. A local model of
// the fixed-point predict and update steps computes the expected angle and
// bias per beat; results are compared in order against the unit's outputs,
// with random gaps on both sides and register changes between phases.
// ----------------------------------------------------------------------------
module angle_kalman_filter_step_unit_test;
    import akf_pkg::*;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam int     SETTLE = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic signed [31:0] i_gyro_rate = '0;
    logic signed [31:0] i_measured_angle = '0;
    logic [15:0] i_time_step = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [31:0] o_angle_estimate;
    logic signed [31:0] o_bias_estimate;

    angle_kalman_filter_step_unit u_top (.*);

    always #6 i_clk = ~i_clk;

    // filter state of the local model
    longint q_angle_m, q_bias_m, r_meas_m;
    longint angle_m, bias_m;
    longint cov_m [4];

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] bias;
    } t_estimate;

    t_estimate estimates_due [$];
    int  errors = 0;
    int  beats_seen = 0;
    bit  hold_long = 1'b0;
    bit  free_run = 1'b0;

    function automatic longint sat_w(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    // round(a*b / 2^sh) with ties away from zero, saturated
    function automatic longint mul_round(longint a, longint b, int sh);
        logic [127:0] m;
        logic [127:0] lim;
        bit neg;
        neg = (a < 0) != (b < 0);
        m = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        m = (m + (128'd1 << (sh - 1))) >> sh;
        lim = 128'(WMAX) + 1;
        if (m > lim) m = lim;
        return sat_w(neg ? -longint'(m) : longint'(m));
    endfunction

    function automatic longint div_round(longint p, longint s);
        logic [127:0] num;
        logic [127:0] d;
        logic [127:0] q;
        logic [127:0] lim;
        bit neg;
        neg = (p < 0) != (s < 0);
        d = 128'(s < 0 ? -s : s);
        num = (128'(p < 0 ? -p : p) << 16) + (d >> 1);
        q = num / d;
        lim = 128'(WMAX) + 1;
        if (q > lim) q = lim;
        return sat_w(neg ? -longint'(q) : longint'(q));
    endfunction

    task automatic filter_update(input longint gyro, input longint meas, input longint dt);
        longint ang, p0, p1, p2, p3, y, s, k0, k1;
        t_estimate e;
        ang = sat_w(angle_m + mul_round(dt, sat_w(gyro - bias_m), 16));
        p0 = sat_w(cov_m[0] + mul_round(dt, q_angle_m, 16)
                   - mul_round(dt, sat_w(cov_m[1] + cov_m[2]), 16));
        p1 = sat_w(cov_m[1] - mul_round(dt, cov_m[3], 16));
        p2 = sat_w(cov_m[2] - mul_round(dt, cov_m[3], 16));
        p3 = sat_w(cov_m[3] + mul_round(dt, q_bias_m, 16));
        y = sat_w(meas - ang);
        s = sat_w(p0 + r_meas_m);
        if (s == 0) begin
            k0 = 0;
            k1 = 0;
        end else begin
            k0 = div_round(p0, s);
            k1 = div_round(p2, s);
        end
        angle_m = sat_w(ang + mul_round(k0, y, 16));
        bias_m = sat_w(bias_m + mul_round(k1, y, 16));
        cov_m[0] = sat_w(p0 - mul_round(k0, p0, 16));
        cov_m[1] = sat_w(p1 - mul_round(k0, p1, 16));
        cov_m[2] = sat_w(p2 - mul_round(k1, p0, 16));
        cov_m[3] = sat_w(p3 - mul_round(k1, p1, 16));
        e.angle = 32'(angle_m);
        e.bias = 32'(bias_m);
        estimates_due.push_back(e);
    endtask

    task automatic send_beat(input logic [31:0] g, input logic [31:0] m, input logic [15:0] dt);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
        if (free_run) gap = 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_gyro_rate <= g;
        i_measured_angle <= m;
        i_time_step <= dt;
        filter_update(longint'($signed(g)), longint'($signed(m)), longint'(dt));
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (estimates_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_Q_ANGLE: q_angle_m = v[30:0];
            REG_Q_BIAS: q_bias_m = v[30:0];
            default: r_meas_m = v[30:0];
        endcase
    endtask

    task automatic set_noise(input logic [31:0] qa, input logic [31:0] qb, input logic [31:0] rm);
        wait_drained();
        write_reg(REG_Q_ANGLE, qa);
        write_reg(REG_Q_BIAS, qb);
        write_reg(REG_R_MEASURE, rm);
    endtask

    task automatic test_directed();
        send_beat(32'h0, 32'h0, 16'h0);
        send_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
        send_beat(32'h8000_0000, 32'h8000_0000, 16'hFFFF);
        send_beat(32'h0001_0000, 32'h0005_0000, 16'h0001);
        send_beat(32'hFFFF_0000, 32'hFFF0_0000, 16'h8000);
        send_beat(32'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
        send_beat(32'h8000_0000, 32'h7FFF_FFFF, 16'h00FF);
        send_beat(32'hFFFF_FFFF, 32'h0000_0001, 16'hFF00);
        send_beat(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555);
        send_beat(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA);
    endtask

    task automatic test_zero_variance();
        // zero q terms and smallest r keep the innovation variance tiny
        set_noise(32'h0, 32'h0, 32'h1);
        repeat (6) send_beat($urandom, $urandom, 16'h0);
        set_noise(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        repeat (6) send_beat($urandom, $urandom, 16'($urandom));
    endtask

    task automatic random_beat();
        logic [31:0] g, m;
        logic [15:0] dt;
        g = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        m = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0B40_0000) - 32'h05A0_0000;
        dt = $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16'h0200));
        send_beat(g, m, dt);
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 5; phase++) begin
            set_noise($urandom_range(0, 4000), $urandom_range(0, 4000),
                      $urandom_range(1, 80000) | (phase == 4 ? 32'h8000_0000 : 32'h0));
            repeat (100) random_beat();
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_long = 1'b1;
        free_run = 1'b1;
        repeat (8) random_beat();
        i_valid <= 1'b0;
        free_run = 1'b0;
        wait (!hold_long);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        q_angle_m = 66;
        q_bias_m = 197;
        r_meas_m = 1966;
        angle_m = 0;
        bias_m = 0;
        foreach (cov_m[i]) cov_m[i] = 0;
        test_directed();
        test_zero_variance();
        test_random();
        test_backpressure();
        wait_drained();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // receiver stall pattern
    initial begin
        int n;
        forever begin
            if (hold_long) begin
                i_stall <= 1'b1;
                repeat (5000) @(posedge i_clk);
                hold_long = 1'b0;
            end
            n = $urandom_range(0, 9);
            if (n < 5) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat (n == 9 ? $urandom_range(50, 400) : $urandom_range(1, 4)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (estimates_due.size() == 0) begin
                $display("%0t unexpected beat angle=%h bias=%h", $time,
                         o_angle_estimate, o_bias_estimate);
                errors++;
            end else begin
                if (o_angle_estimate !== estimates_due[0].angle) begin
                    $display("%0t angle exp=%h act=%h", $time,
                             estimates_due[0].angle, o_angle_estimate);
                    errors++;
                end
                if (o_bias_estimate !== estimates_due[0].bias) begin
                    $display("%0t bias exp=%h act=%h", $time,
                             estimates_due[0].bias, o_bias_estimate);
                    errors++;
                end
                void'(estimates_due.pop_front());
            end
            beats_seen++;
        end
    end

    initial begin
        #(12 * 4_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/akf_pkg.sv
rtl/akf_alu.sv
rtl/angle_kalman_filter_step_unit.sv
tb/angle_kalman_filter_step_unit_test.sv
